### rtl/booth_pkg.sv
`timescale 1ns / 1ps

package booth_pkg;

   // operand width; the payload structs are fixed by it
   localparam int BOOTH_WIDTH = 8;
   localparam int ROUND_W     = 4;

   typedef enum logic [1:0] {
      OP_INIT  = 2'd0,
      OP_SUB   = 2'd1,
      OP_ADD   = 2'd2,
      OP_SHIFT = 2'd3
   } op_type;

   typedef struct packed {
      logic signed [BOOTH_WIDTH-1:0] multiplier;
      logic signed [BOOTH_WIDTH-1:0] multiplicand;
   } req_type;

   typedef struct packed {
      logic [ROUND_W-1:0]              round;
      op_type                          operation;
      logic [BOOTH_WIDTH-1:0]          accumulator;
      logic [BOOTH_WIDTH-1:0]          multiplier_reg;
      logic                            q_minus_one;
      logic signed [2*BOOTH_WIDTH-1:0] product;
      logic                            last;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic               load;
      logic               addsub;
      logic               sub;
      logic               shift;
      logic               last;
      logic [ROUND_W-1:0] round;
   } booth_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic q0;
      logic q1;
   } booth_status_type;

endpackage

### rtl/booth_ctrl.sv
`timescale 1ns / 1ps

module booth_ctrl
   import booth_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  booth_status_type status,
   output booth_cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXAMINE,
      ST_SHIFT
   } state_type;

   localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(BOOTH_WIDTH);

   state_type          state_ff, state_in;
   logic [ROUND_W-1:0] round_ff, round_in;
   logic               busy_ff, busy_in;

   assign busy = busy_ff;

   always_comb begin
      state_in = state_ff;
      round_in = round_ff;
      cmd      = '0;
      cmd.round = round_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load  = 1'b1;
               cmd.round = '0;
               round_in  = ROUND_W'(1);
               state_in  = ST_EXAMINE;
            end
         end
         ST_EXAMINE: begin
            if (status.q0 != status.q1) begin
               cmd.addsub = 1'b1;
               cmd.sub    = status.q0;
               state_in   = ST_SHIFT;
            end else begin
               // nothing to add: shift right away
               cmd.shift = 1'b1;
               cmd.last  = (round_ff == LAST_ROUND);
               round_in  = round_ff + 1'b1;
               state_in  = cmd.last ? ST_IDLE : ST_EXAMINE;
            end
         end
         ST_SHIFT: begin
            cmd.shift = 1'b1;
            cmd.last  = (round_ff == LAST_ROUND);
            round_in  = round_ff + 1'b1;
            state_in  = cmd.last ? ST_IDLE : ST_EXAMINE;
         end
         default: state_in = ST_IDLE;
      endcase
      busy_in = (state_in != ST_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         round_ff <= '0;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         round_ff <= round_in;
         busy_ff  <= busy_in;
      end
   end

endmodule

### rtl/booth_datapath.sv
`timescale 1ns / 1ps

module booth_datapath
   import booth_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  req_type          req_data,
   input  booth_cmd_type    cmd,
   output booth_status_type status,
   output logic             rsp_strobe,
   output rsp_type          rsp_data
);

   localparam int W = BOOTH_WIDTH;

   logic [W-1:0] a_ff, a_in;
   logic [W-1:0] q_ff, q_in;
   logic         q1_ff, q1_in;
   logic [W-1:0] m_ff, m_in;
   rsp_type      rsp_ff, rsp_in;
   logic         strobe_ff, strobe_in;

   assign status.q0  = q_ff[0];
   assign status.q1  = q1_ff;
   assign rsp_data   = rsp_ff;
   assign rsp_strobe = strobe_ff;

   always_comb begin
      a_in      = a_ff;
      q_in      = q_ff;
      q1_in     = q1_ff;
      m_in      = m_ff;
      rsp_in    = rsp_ff;
      strobe_in = cmd.load | cmd.addsub | cmd.shift;

      if (cmd.load) begin
         a_in  = '0;
         q_in  = req_data.multiplier;
         q1_in = 1'b0;
         m_in  = req_data.multiplicand;
      end else if (cmd.addsub) begin
         a_in = cmd.sub ? (a_ff - m_ff) : (a_ff + m_ff);
      end else if (cmd.shift) begin
         // arithmetic shift of A:Q:Q-1
         q1_in = q_ff[0];
         q_in  = {a_ff[0], q_ff[W-1:1]};
         a_in  = {a_ff[W-1], a_ff[W-1:1]};
      end

      rsp_in.round          = cmd.round;
      rsp_in.accumulator    = a_in;
      rsp_in.multiplier_reg = q_in;
      rsp_in.q_minus_one    = q1_in;
      rsp_in.last           = cmd.last;
      rsp_in.product        = cmd.last ? {a_in, q_in} : '0;
      if (cmd.load) begin
         rsp_in.operation = OP_INIT;
      end else if (cmd.addsub) begin
         rsp_in.operation = cmd.sub ? OP_SUB : OP_ADD;
      end else begin
         rsp_in.operation = OP_SHIFT;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      q_ff   <= q_in;
      q1_ff  <= q1_in;
      m_ff   <= m_in;
      rsp_ff <= rsp_in;
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= strobe_in;
      end
   end

endmodule

### rtl/booth_radix2_multiplier.sv
`timescale 1ns / 1ps

// channel  | ports                     | handshake
// ---------+---------------------------+--------------------------------------
// request  | start, busy, req_data     | taken on a clock edge with start & !busy
// result   | rsp_strobe, rsp_data      | one cycle per result, no backpressure
//
// One result leaves per cycle: the init result in the cycle after the request,
// then one per add/subtract and one per shift, the last carrying the product.
// The length of a request is set by the single shared adder and the shift
// step of the controller; busy stays high while a request is in progress.
// The final result appears in the cycle in which a new request may be taken.
// Synchronous active-high reset clears the controller and the result strobe.
module booth_radix2_multiplier
   import booth_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   booth_cmd_type    cmd;
   booth_status_type status;

   booth_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   booth_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cmd        (cmd),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule
